/* rtl/assert_macros.svh */
// Assertion macros shared by the RTL of the reachability block.
// Depends on nothing; the macros expand to nothing when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Implication or plain property checked on every rising clock edge outside reset.
`define ASSERT_PROP(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Expression that must never be true outside reset.
`define ASSERT_NEVER(lbl, clk, rst_n, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define ASSERT_PROP(lbl, clk, rst_n, prop, msg)
`define ASSERT_NEVER(lbl, clk, rst_n, expr, msg)
`endif
`endif

/* rtl/getr_pkg.sv */
// Package for the graph reachability block: sizes, operation codes, state type.
// Depends on nothing.
`default_nettype none
package getr_pkg;

    // Number of vertices and the width of a vertex index.
    localparam int NODES  = 32;
    localparam int NODE_W = (NODES > 1) ? $clog2(NODES) : 1;

    // One adjacency row or one vertex set.
    typedef logic [NODES-1:0] t_row;

    // Operation codes carried by an input word.
    typedef enum logic [1:0] {
        OP_ADD    = 2'd0,
        OP_REMOVE = 2'd1,
        OP_QUERY  = 2'd2
    } t_op;

    // Controller states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EDGE,
        ST_QUERY,
        ST_DONE
    } t_state;

endpackage
`default_nettype wire

/* rtl/graph_edge_table_reachability.sv */
// Top level of the directed graph reachability block: adjacency memory and controller.
// Depends on getr_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

// Directed graph over 32 vertices, held as one adjacency row per vertex in a
// synchronous RAM with a registered read. One word is taken at a time and gives
// exactly one answer word. Add and remove read the source row on accept, then
// modify and write it back in ST_EDGE, and ST_DONE loads the answer into the
// output register. A query reads the source row and then expands one reached,
// not yet expanded vertex per cycle through the single RAM read port, stopping as
// soon as the destination is reached or nothing is left to expand. At most
// NODES - 1 vertices other than the destination can be expanded. Words that need
// no memory access (unused code, absent vertex) go from accept straight to ST_DONE.
// Rows are marked valid by per-row flip-flops that reset clears, so no clearing
// pass runs after reset. The output register lets a new word be accepted while
// an answer still waits to be taken.
module graph_edge_table_reachability
    import getr_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    // Input channel
    input  wire logic              i_in_valid,
    output logic                   o_in_stall,
    input  wire logic [1:0]        i_operation,
    input  wire logic [4:0]        i_src_node,
    input  wire logic [4:0]        i_dst_node,
    // Output channel
    output logic                   o_out_valid,
    input  wire logic              i_out_stall,
    output logic                   o_answer
);

    // Index of the lowest set bit of a vertex set.
    function automatic logic [NODE_W-1:0] lowest_set(input t_row bits);
        logic [NODE_W-1:0] idx;
        idx = '0;
        for (int i = NODES - 1; i >= 0; i--) begin
            if (bits[i]) idx = NODE_W'(i);
        end
        return idx;
    endfunction

    // Registers and their next values.
    t_state              r_state, n_state;
    t_op                 r_op, n_op;
    logic [NODE_W-1:0]   r_src, n_src;
    logic [NODE_W-1:0]   r_dst, n_dst;
    t_row                r_frontier, n_frontier;
    t_row                r_visited, n_visited;
    logic                r_inflight, n_inflight;
    logic                r_res, n_res;
    t_row                r_present, n_present;
    t_row                r_row_valid, n_row_valid;
    logic                r_out_valid, n_out_valid;
    logic                r_out_answer, n_out_answer;

    // Adjacency memory and its registered read port.
    t_row                mem [NODES];
    t_row                r_rd_data;
    logic                r_rd_valid;
    logic                mem_re;
    logic [NODE_W-1:0]   mem_raddr;
    logic                mem_we;
    logic [NODE_W-1:0]   mem_waddr;
    t_row                mem_wdata;

    // Helper signals.
    logic                accept;
    logic                in_range;
    logic [NODE_W-1:0]   in_src;
    logic [NODE_W-1:0]   in_dst;
    t_row                row_in;
    t_row                f_eff;
    t_row                pending;
    t_row                dst_bit;

    assign o_in_stall  = (r_state != ST_IDLE);
    assign accept      = i_in_valid && !o_in_stall;
    assign in_src      = NODE_W'(i_src_node);
    assign in_dst      = NODE_W'(i_dst_node);
    assign in_range    = (32'(i_src_node) < NODES) && (32'(i_dst_node) < NODES);
    assign o_out_valid = r_out_valid;
    assign o_answer    = r_out_answer;

    // Row that came out of the memory; a row never written reads as empty.
    assign row_in  = r_rd_valid ? r_rd_data : '0;
    // Reached set including the row that is arriving this cycle.
    assign f_eff   = r_frontier | (r_inflight ? row_in : '0);
    assign pending = f_eff & ~r_visited;
    assign dst_bit = t_row'(1) << r_dst;

    // Memory: one write and one registered read per cycle.
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            r_rd_data  <= mem[mem_raddr];
            r_rd_valid <= r_row_valid[mem_raddr];
        end
    end

    // Controller state and datapath registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_frontier   <= '0;
            r_visited    <= '0;
            r_inflight   <= 1'b0;
            r_present    <= '0;
            r_row_valid  <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_frontier   <= n_frontier;
            r_visited    <= n_visited;
            r_inflight   <= n_inflight;
            r_present    <= n_present;
            r_row_valid  <= n_row_valid;
            r_out_valid  <= n_out_valid;
        end
        r_op         <= n_op;
        r_src        <= n_src;
        r_dst        <= n_dst;
        r_res        <= n_res;
        r_out_answer <= n_out_answer;
    end

    // Next state, memory control and result.
    always_comb begin
        n_state      = r_state;
        n_op         = r_op;
        n_src        = r_src;
        n_dst        = r_dst;
        n_frontier   = r_frontier;
        n_visited    = r_visited;
        n_inflight   = r_inflight;
        n_res        = r_res;
        n_present    = r_present;
        n_row_valid  = r_row_valid;
        n_out_valid  = r_out_valid && i_out_stall;
        n_out_answer = r_out_answer;
        mem_re       = 1'b0;
        mem_raddr    = r_src;
        mem_we       = 1'b0;
        mem_waddr    = r_src;
        mem_wdata    = row_in;

        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_src = in_src;
                    n_dst = in_dst;
                    n_op  = t_op'(i_operation);
                    n_res = 1'b0;
                    n_state = ST_DONE;
                    if (in_range) begin
                        unique case (t_op'(i_operation))
                            OP_ADD: begin
                                n_present[in_src] = 1'b1;
                                n_present[in_dst] = 1'b1;
                                mem_re    = 1'b1;
                                mem_raddr = in_src;
                                n_state   = ST_EDGE;
                            end
                            OP_REMOVE: begin
                                if (r_present[in_src] && r_present[in_dst]) begin
                                    mem_re    = 1'b1;
                                    mem_raddr = in_src;
                                    n_state   = ST_EDGE;
                                end
                            end
                            OP_QUERY: begin
                                if (r_present[in_src] && r_present[in_dst]) begin
                                    mem_re     = 1'b1;
                                    mem_raddr  = in_src;
                                    n_frontier = '0;
                                    n_visited  = '0;
                                    n_inflight = 1'b1;
                                    n_state    = ST_QUERY;
                                end
                            end
                            default: begin
                                n_state = ST_DONE;
                            end
                        endcase
                    end
                end
            end

            // Source row is here: set or clear the edge and write it back.
            ST_EDGE: begin
                mem_we    = 1'b1;
                mem_waddr = r_src;
                n_row_valid[r_src] = 1'b1;
                if (r_op == OP_ADD) begin
                    mem_wdata = row_in | dst_bit;
                    n_res     = 1'b0;
                end else begin
                    mem_wdata = row_in & ~dst_bit;
                    n_res     = |(row_in & dst_bit);
                end
                n_state = ST_DONE;
            end

            // Expand one pending vertex per cycle until done.
            ST_QUERY: begin
                n_frontier = f_eff;
                if (|(f_eff & dst_bit)) begin
                    n_res      = 1'b1;
                    n_inflight = 1'b0;
                    n_state    = ST_DONE;
                end else if (pending == '0) begin
                    n_res      = 1'b0;
                    n_inflight = 1'b0;
                    n_state    = ST_DONE;
                end else begin
                    mem_re     = 1'b1;
                    mem_raddr  = lowest_set(pending);
                    n_visited[lowest_set(pending)] = 1'b1;
                    n_inflight = 1'b1;
                end
            end

            // Hand the answer to the output register once it is free.
            ST_DONE: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out_valid  = 1'b1;
                    n_out_answer = r_res;
                    n_state      = ST_IDLE;
                end
            end

            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Checks on the controller.
    `ASSERT_NEVER(a_visited_reached, i_clk, i_rst_n, (r_visited & ~r_frontier) != '0, "expanded vertex not in reached set")
    `ASSERT_PROP(a_query_read, i_clk, i_rst_n, (r_state == ST_QUERY) |-> r_inflight, "query without a row read in flight")
    `ASSERT_PROP(a_edge_from_idle, i_clk, i_rst_n, (r_state == ST_EDGE) |-> ($past(r_state) == ST_IDLE), "edge update not right after accept")
    `ASSERT_PROP(a_out_from_done, i_clk, i_rst_n, $rose(o_out_valid) |-> ($past(r_state) == ST_DONE), "answer loaded outside done state")

endmodule
`default_nettype wire
